/* hdl/projection_surface_power_defines.svh */
// Assertion macros shared by the projection and surface power RTL.
// Included by modules that carry concurrent checks; needs no other file.
`ifndef PROJECTION_SURFACE_POWER_DEFINES_SVH
`define PROJECTION_SURFACE_POWER_DEFINES_SVH

`ifndef SYNTHESIS
`define PSP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PSP_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define PSP_ASSERT(lbl, clk, rstn, prop, msg)
`define PSP_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

/* hdl/psp_pkg.sv */
// Package for the projection and surface power block: payload types, widths,
// register indexes and pipeline stage records. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package psp_pkg;

    localparam int POS_W      = 32;
    localparam int NORM_W     = 16;
    localparam int PROJ_W     = 48;
    localparam int POWER_W    = 32;
    localparam int KR_W       = 20;
    localparam int ROW_W      = 3 * KR_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ROW_W;
    localparam int TERM_W     = 59;
    localparam int NUM_W      = 108;
    localparam int DEN_W      = 143;
    localparam int MAG_N_W    = NUM_W - 1;
    localparam int MAG_D_W    = DEN_W - 1;
    localparam int DIV_W      = DEN_W;
    localparam int Q_W        = 32;
    localparam int DIV_STAGES = Q_W;

    localparam logic signed [POWER_W-1:0] POWER_MAX = {1'b0, {(POWER_W-1){1'b1}}};
    localparam logic signed [POWER_W-1:0] POWER_MIN = {1'b1, {(POWER_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KR_ROW0  = 3'd0,
        CFG_KR_ROW1  = 3'd1,
        CFG_KR_ROW2  = 3'd2,
        CFG_OFFSET_U = 3'd3,
        CFG_OFFSET_V = 3'd4,
        CFG_OFFSET_W = 3'd5
    } psp_cfg_idx_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic signed [NORM_W-1:0] norm_x;
        logic signed [NORM_W-1:0] norm_y;
        logic signed [NORM_W-1:0] norm_z;
    } psp_in_t;

    typedef struct packed {
        logic signed [PROJ_W-1:0]  proj_u;
        logic signed [PROJ_W-1:0]  proj_v;
        logic signed [PROJ_W-1:0]  proj_w;
        logic signed [POWER_W-1:0] power_val;
        logic                      depth_zero;
        logic                      power_saturated;
    } psp_out_t;

    typedef struct packed {
        logic [ROW_W-1:0]         kr_row0;
        logic [ROW_W-1:0]         kr_row1;
        logic [ROW_W-1:0]         kr_row2;
        logic signed [PROJ_W-1:0] offset_u;
        logic signed [PROJ_W-1:0] offset_v;
        logic signed [PROJ_W-1:0] offset_w;
    } psp_cfg_t;

    typedef struct packed {
        logic signed [PROJ_W-1:0] u;
        logic signed [PROJ_W-1:0] v;
        logic signed [PROJ_W-1:0] w;
    } psp_proj_t;

    typedef struct packed {
        logic                     valid;
        psp_proj_t                proj;
        logic signed [TERM_W-1:0] ta;
        logic signed [TERM_W-1:0] tb;
        logic signed [TERM_W-1:0] tc;
    } psp_terms_t;

    typedef struct packed {
        logic             valid;
        psp_proj_t        proj;
        logic             zero;
        logic             negres;
        logic             big;
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] dvs;
        logic [Q_W-1:0]   quo;
    } psp_div_t;

endpackage

`default_nettype wire

/* hdl/psp_cfg.sv */
// Configuration registers: matrix rows and offset, written by index.
// Depends on psp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psp_cfg import psp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output psp_cfg_t              cfg
);

    psp_cfg_t cfg_reg;
    psp_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (psp_cfg_idx_t'(cfg_addr))
                CFG_KR_ROW0:  cfg_next.kr_row0  = cfg_wdata[ROW_W-1:0];
                CFG_KR_ROW1:  cfg_next.kr_row1  = cfg_wdata[ROW_W-1:0];
                CFG_KR_ROW2:  cfg_next.kr_row2  = cfg_wdata[ROW_W-1:0];
                CFG_OFFSET_U: cfg_next.offset_u = $signed(cfg_wdata[PROJ_W-1:0]);
                CFG_OFFSET_V: cfg_next.offset_v = $signed(cfg_wdata[PROJ_W-1:0]);
                CFG_OFFSET_W: cfg_next.offset_w = $signed(cfg_wdata[PROJ_W-1:0]);
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* hdl/psp_front.sv */
// Front pipeline: projection dot products, rounding, offset and saturation,
// plus the normal-weighted cross terms of the matrix rows. Depends on psp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psp_front import psp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic       in_valid,
    output logic       in_ready,
    input  psp_in_t    in_data,
    input  psp_cfg_t   cfg,
    output psp_terms_t out
);

    localparam int PROD_W = KR_W + POS_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int RND_W  = SUM_W + 1;
    localparam int DIFF_W = PROJ_W + 8;
    localparam int XP_W   = 2 * KR_W;
    localparam int CR_W   = XP_W + 1;
    localparam int NC_W   = CR_W + NORM_W;
    localparam int PA [3]  = '{0, 0, 1};
    localparam int PB [3]  = '{1, 2, 2};
    localparam int NX1 [3] = '{1, 2, 0};
    localparam int NX2 [3] = '{2, 0, 1};
    localparam logic signed [DIFF_W-1:0] P_MAX = DIFF_W'({1'b0, {(PROJ_W-1){1'b1}}});
    localparam logic signed [DIFF_W-1:0] P_MIN = -P_MAX - DIFF_W'(1);

    logic [ROW_W-1:0]          rows [3];
    logic signed [KR_W-1:0]    kr [3][3];
    logic signed [POS_W-1:0]   pos [3];
    logic signed [NORM_W-1:0]  nrm [3];
    logic signed [PROJ_W-1:0]  off [3];

    logic [3:0] vld_reg;
    logic       ld0;

    logic signed [PROD_W-1:0] a_prod_reg [3][3], a_prod_next [3][3];
    logic signed [XP_W-1:0]   a_xp_reg [3][3][2], a_xp_next [3][3][2];
    logic signed [NORM_W-1:0] a_norm_reg [3];

    logic signed [SUM_W-1:0]  b_sum_reg [3], b_sum_next [3];
    logic signed [CR_W-1:0]   b_cr_reg [3][3], b_cr_next [3][3];
    logic signed [NORM_W-1:0] b_norm_reg [3];

    logic signed [PROJ_W-1:0] c_proj_reg [3], c_proj_next [3];
    logic signed [NC_W-1:0]   c_nc_reg [3][3], c_nc_next [3][3];

    logic signed [PROJ_W-1:0] d_proj_reg [3];
    logic signed [TERM_W-1:0] d_term_reg [3], d_term_next [3];

    logic signed [RND_W-1:0]  rnd;
    logic signed [DIFF_W-1:0] diff;

    assign ld0      = en || !vld_reg[0];
    assign in_ready = ld0;

    always_comb begin
        rows[0] = cfg.kr_row0;
        rows[1] = cfg.kr_row1;
        rows[2] = cfg.kr_row2;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                kr[i][j] = $signed(rows[i][j*KR_W +: KR_W]);
            end
        end
        pos[0] = in_data.pos_x;
        pos[1] = in_data.pos_y;
        pos[2] = in_data.pos_z;
        nrm[0] = in_data.norm_x;
        nrm[1] = in_data.norm_y;
        nrm[2] = in_data.norm_z;
        off[0] = cfg.offset_u;
        off[1] = cfg.offset_v;
        off[2] = cfg.offset_w;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                a_prod_next[i][j] = PROD_W'(kr[i][j]) * PROD_W'(pos[j]);
            end
        end
        for (int k = 0; k < 3; k++) begin
            for (int m = 0; m < 3; m++) begin
                a_xp_next[k][m][0] = XP_W'(kr[PA[k]][NX1[m]]) * XP_W'(kr[PB[k]][NX2[m]]);
                a_xp_next[k][m][1] = XP_W'(kr[PA[k]][NX2[m]]) * XP_W'(kr[PB[k]][NX1[m]]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            b_sum_next[i] = SUM_W'(a_prod_reg[i][0]) + SUM_W'(a_prod_reg[i][1])
                          + SUM_W'(a_prod_reg[i][2]);
        end
        for (int k = 0; k < 3; k++) begin
            for (int m = 0; m < 3; m++) begin
                b_cr_next[k][m] = CR_W'(a_xp_reg[k][m][0]) - CR_W'(a_xp_reg[k][m][1]);
            end
        end
    end

    always_comb begin
        rnd  = '0;
        diff = '0;
        for (int i = 0; i < 3; i++) begin
            rnd  = (RND_W'(b_sum_reg[i]) + RND_W'(128)) >>> 8;
            diff = DIFF_W'(rnd) - DIFF_W'(off[i]);
            priority if (diff > P_MAX) begin
                c_proj_next[i] = PROJ_W'(P_MAX);
            end else if (diff < P_MIN) begin
                c_proj_next[i] = PROJ_W'(P_MIN);
            end else begin
                c_proj_next[i] = PROJ_W'(diff);
            end
        end
        for (int k = 0; k < 3; k++) begin
            for (int m = 0; m < 3; m++) begin
                c_nc_next[k][m] = NC_W'(b_norm_reg[m]) * NC_W'(b_cr_reg[k][m]);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d_term_next[k] = TERM_W'(c_nc_reg[k][0]) + TERM_W'(c_nc_reg[k][1])
                           + TERM_W'(c_nc_reg[k][2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (ld0) begin
                vld_reg[0] <= in_valid;
            end
            if (en) begin
                vld_reg[3:1] <= vld_reg[2:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld0) begin
            a_prod_reg <= a_prod_next;
            a_xp_reg   <= a_xp_next;
            a_norm_reg <= nrm;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_sum_reg  <= b_sum_next;
            b_cr_reg   <= b_cr_next;
            b_norm_reg <= a_norm_reg;
            c_proj_reg <= c_proj_next;
            c_nc_reg   <= c_nc_next;
            d_proj_reg <= c_proj_reg;
            d_term_reg <= d_term_next;
        end
    end

    always_comb begin
        out.valid  = vld_reg[3];
        out.proj.u = d_proj_reg[0];
        out.proj.v = d_proj_reg[1];
        out.proj.w = d_proj_reg[2];
        out.ta     = d_term_reg[0];
        out.tb     = d_term_reg[1];
        out.tc     = d_term_reg[2];
    end

endmodule

`default_nettype wire

/* hdl/psp_numden.sv */
// Numerator and cubed-depth pipeline: split wide products into partials,
// sum them, take magnitudes and form the rounded dividend. Depends on psp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psp_numden import psp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  psp_terms_t tin,
    output psp_div_t   dout
);

    localparam int LO_W  = 24;
    localparam int TL_W  = 30;
    localparam int TH_W  = TERM_W - TL_W;
    localparam int PP_W  = 56;
    localparam int WW_W  = 50;
    localparam int W2_W  = 96;
    localparam int DC_W  = WW_W + LO_W;
    localparam int CMP_W = DIV_W + Q_W;

    logic [7:0] vld_reg;

    logic signed [PROJ_W-1:0] mx [3];
    logic signed [TERM_W-1:0] my [3];
    logic [LO_W-1:0]          xl, wl, ck;
    logic signed [LO_W-1:0]   xh, wh;
    logic [TL_W-1:0]          yl;
    logic signed [TH_W-1:0]   yh;
    logic [LO_W-1:0]          gwl;
    logic signed [LO_W-1:0]   gwh;

    psp_proj_t                e_proj_reg, f_proj_reg, g_proj_reg, h_proj_reg;
    psp_proj_t                i_proj_reg, j_proj_reg, k_proj_reg, l_proj_reg;
    logic signed [PP_W-1:0]   e_pp_reg [3][4], e_pp_next [3][4];
    logic signed [WW_W-1:0]   e_ww_reg [3], e_ww_next [3];
    logic signed [NUM_W-1:0]  f_prod_reg [3], f_prod_next [3];
    logic signed [W2_W-1:0]   f_w2_reg, f_w2_next;
    logic signed [NUM_W-1:0]  g_num_reg, g_num_next;
    logic signed [WW_W-1:0]   g_dp_reg [4][2], g_dp_next [4][2];
    logic signed [NUM_W-1:0]  h_num_reg;
    logic signed [DC_W-1:0]   h_dc_reg [4], h_dc_next [4];
    logic signed [DEN_W-1:0]  i_den_reg, i_den_next;
    logic [MAG_N_W-1:0]       i_an_reg, i_an_next;
    logic                     i_nneg_reg;
    logic [MAG_N_W-1:0]       j_an_reg;
    logic [MAG_D_W-1:0]       j_ad_reg, j_ad_next;
    logic                     j_neg_reg, j_neg_next, j_zero_reg, j_zero_next;
    logic [DIV_W-1:0]         k_x_reg, k_x_next, k_y_reg, k_y_next;
    logic                     k_neg_reg, k_zero_reg;
    logic [DIV_W-1:0]         l_x_reg, l_y_reg;
    logic                     l_neg_reg, l_zero_reg, l_big_reg, l_big_next;

    always_comb begin
        mx[0] = tin.proj.w;
        mx[1] = tin.proj.v;
        mx[2] = tin.proj.u;
        my[0] = tin.ta;
        my[1] = tin.tb;
        my[2] = tin.tc;
        xl = '0;
        xh = '0;
        yl = '0;
        yh = '0;
        for (int k = 0; k < 3; k++) begin
            xl = mx[k][LO_W-1:0];
            xh = $signed(mx[k][PROJ_W-1:LO_W]);
            yl = my[k][TL_W-1:0];
            yh = $signed(my[k][TERM_W-1:TL_W]);
            e_pp_next[k][0] = PP_W'($signed({1'b0, xl})) * PP_W'($signed({1'b0, yl}));
            e_pp_next[k][1] = PP_W'($signed({1'b0, xl})) * PP_W'(yh);
            e_pp_next[k][2] = PP_W'(xh) * PP_W'($signed({1'b0, yl}));
            e_pp_next[k][3] = PP_W'(xh) * PP_W'(yh);
        end
        wl = tin.proj.w[LO_W-1:0];
        wh = $signed(tin.proj.w[PROJ_W-1:LO_W]);
        e_ww_next[0] = WW_W'($signed({1'b0, wl})) * WW_W'($signed({1'b0, wl}));
        e_ww_next[1] = WW_W'($signed({1'b0, wl})) * WW_W'(wh);
        e_ww_next[2] = WW_W'(wh) * WW_W'(wh);
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            f_prod_next[k] = NUM_W'(e_pp_reg[k][0])
                           + (NUM_W'(e_pp_reg[k][1]) <<< TL_W)
                           + (NUM_W'(e_pp_reg[k][2]) <<< LO_W)
                           + (NUM_W'(e_pp_reg[k][3]) <<< (TL_W + LO_W));
        end
        f_w2_next = W2_W'(e_ww_reg[0]) + (W2_W'(e_ww_reg[1]) <<< (LO_W + 1))
                  + (W2_W'(e_ww_reg[2]) <<< (2 * LO_W));
    end

    always_comb begin
        g_num_next = f_prod_reg[1] - f_prod_reg[0] - f_prod_reg[2];
        gwl = f_proj_reg.w[LO_W-1:0];
        gwh = $signed(f_proj_reg.w[PROJ_W-1:LO_W]);
        ck  = '0;
        for (int j = 0; j < 4; j++) begin
            ck = f_w2_reg[j*LO_W +: LO_W];
            g_dp_next[j][0] = WW_W'($signed({1'b0, ck})) * WW_W'($signed({1'b0, gwl}));
            g_dp_next[j][1] = WW_W'($signed({1'b0, ck})) * WW_W'(gwh);
        end
    end

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            h_dc_next[j] = DC_W'(g_dp_reg[j][0]) + (DC_W'(g_dp_reg[j][1]) <<< LO_W);
        end
    end

    always_comb begin
        i_den_next = DEN_W'(h_dc_reg[0]) + (DEN_W'(h_dc_reg[1]) <<< LO_W)
                   + (DEN_W'(h_dc_reg[2]) <<< (2 * LO_W))
                   + (DEN_W'(h_dc_reg[3]) <<< (3 * LO_W));
        i_an_next  = h_num_reg[NUM_W-1] ? MAG_N_W'(-h_num_reg) : MAG_N_W'(h_num_reg);
    end

    always_comb begin
        j_ad_next   = i_den_reg[DEN_W-1] ? MAG_D_W'(-i_den_reg) : MAG_D_W'(i_den_reg);
        j_neg_next  = i_nneg_reg ^ i_den_reg[DEN_W-1];
        j_zero_next = (i_proj_reg.w == '0);
    end

    always_comb begin
        k_x_next = (DIV_W'(j_an_reg) << 19) + DIV_W'(j_ad_reg);
        k_y_next = DIV_W'(j_ad_reg) << 1;
    end

    assign l_big_next = {{Q_W{1'b0}}, k_x_reg} >= CMP_W'({k_y_reg, {Q_W{1'b0}}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[6:0], tin.valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_proj_reg <= tin.proj;
            e_pp_reg   <= e_pp_next;
            e_ww_reg   <= e_ww_next;
            f_proj_reg <= e_proj_reg;
            f_prod_reg <= f_prod_next;
            f_w2_reg   <= f_w2_next;
            g_proj_reg <= f_proj_reg;
            g_num_reg  <= g_num_next;
            g_dp_reg   <= g_dp_next;
            h_proj_reg <= g_proj_reg;
            h_num_reg  <= g_num_reg;
            h_dc_reg   <= h_dc_next;
            i_proj_reg <= h_proj_reg;
            i_den_reg  <= i_den_next;
            i_an_reg   <= i_an_next;
            i_nneg_reg <= h_num_reg[NUM_W-1];
            j_proj_reg <= i_proj_reg;
            j_an_reg   <= i_an_reg;
            j_ad_reg   <= j_ad_next;
            j_neg_reg  <= j_neg_next;
            j_zero_reg <= j_zero_next;
            k_proj_reg <= j_proj_reg;
            k_x_reg    <= k_x_next;
            k_y_reg    <= k_y_next;
            k_neg_reg  <= j_neg_reg;
            k_zero_reg <= j_zero_reg;
            l_proj_reg <= k_proj_reg;
            l_x_reg    <= k_x_reg;
            l_y_reg    <= k_y_reg;
            l_neg_reg  <= k_neg_reg;
            l_zero_reg <= k_zero_reg;
            l_big_reg  <= l_big_next;
        end
    end

    always_comb begin
        dout.valid  = vld_reg[7];
        dout.proj   = l_proj_reg;
        dout.zero   = l_zero_reg;
        dout.negres = l_neg_reg;
        dout.big    = l_big_reg;
        dout.rem    = l_x_reg;
        dout.dvs    = l_y_reg;
        dout.quo    = '0;
    end

endmodule

`default_nettype wire

/* hdl/psp_div.sv */
// Pipelined restoring divider, one quotient bit per stage, most significant
// first. Depends on psp_pkg and projection_surface_power_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "projection_surface_power_defines.svh"

module psp_div import psp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     en,
    input  psp_div_t din,
    output psp_div_t dout
);

    psp_div_t stg_reg [DIV_STAGES];
    psp_div_t stg_in [DIV_STAGES];
    psp_div_t stg_next [DIV_STAGES];

    always_comb begin
        stg_in[0] = din;
        for (int k = 1; k < DIV_STAGES; k++) begin
            stg_in[k] = stg_reg[k-1];
        end
    end

    always_comb begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            stg_next[k] = stg_in[k];
            if ((stg_in[k].rem >> (Q_W - 1 - k)) >= stg_in[k].dvs) begin
                stg_next[k].rem = stg_in[k].rem - (stg_in[k].dvs << (Q_W - 1 - k));
                stg_next[k].quo[Q_W-1-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                stg_reg[k].valid <= 1'b0;
            end
        end else if (en) begin
            stg_reg <= stg_next;
        end
    end

    assign dout = stg_reg[DIV_STAGES-1];

    `PSP_ASSERT(a_rem_below_divisor, aclk, aresetn, (dout.valid && !dout.big) |-> (dout.rem < dout.dvs), "remainder not below divisor")

endmodule

`default_nettype wire

/* hdl/projection_surface_power.sv */
// Top level of the projection and surface power block: config registers,
// front, numerator/denominator and divider pipelines, output register.
// Depends on psp_pkg, psp_cfg, psp_front, psp_numden, psp_div and the defines header.
//
//   port group  | dir | handshake        | payload
//   s_          | in  | s_valid/s_ready  | s_data  (psp_in_t)
//   m_          | out | m_valid/m_ready  | m_data  (psp_out_t)
//   cfg_        | in  | cfg_we           | cfg_addr, cfg_wdata
//
// One transaction per cycle sustained while the output is not stalled; each result passes
// through 45 register stages (4 front, 8 numerator/denominator, 32 divider, 1 output).
// The divider has 32 stages, one quotient bit per stage.
// Reset clears the config registers and all stage valid bits.
// m_ready low while m_valid is high freezes every stage; an empty first stage still takes a transaction.
`timescale 1ns / 1ps
`default_nettype none
`include "projection_surface_power_defines.svh"

module projection_surface_power import psp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  psp_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output psp_out_t              m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    psp_cfg_t   cfg;
    psp_terms_t terms;
    psp_div_t   div_in;
    psp_div_t   div_out;
    logic       en;
    logic       ovf;

    logic     m_valid_reg;
    psp_out_t m_data_reg, m_data_next;

    assign en = !m_valid_reg || m_ready;

    psp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    psp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_data  (s_data),
        .cfg      (cfg),
        .out      (terms)
    );

    psp_numden u_numden (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .tin     (terms),
        .dout    (div_in)
    );

    psp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .din     (div_in),
        .dout    (div_out)
    );

    always_comb begin
        m_data_next.proj_u          = div_out.proj.u;
        m_data_next.proj_v          = div_out.proj.v;
        m_data_next.proj_w          = div_out.proj.w;
        m_data_next.depth_zero      = div_out.zero;
        m_data_next.power_saturated = 1'b0;
        m_data_next.power_val       = '0;
        ovf = 1'b0;
        if (!div_out.zero) begin
            if (div_out.negres) begin
                ovf = div_out.big || (div_out.quo[Q_W-1] && (|div_out.quo[Q_W-2:0]));
                m_data_next.power_val = ovf ? POWER_MIN
                                            : $signed(POWER_W'(-div_out.quo));
            end else begin
                ovf = div_out.big || div_out.quo[Q_W-1];
                m_data_next.power_val = ovf ? POWER_MAX : $signed(div_out.quo);
            end
            m_data_next.power_saturated = ovf;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= div_out.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `PSP_ASSERT(a_zero_forces_power, aclk, aresetn, (m_valid_reg && m_data_reg.depth_zero) |-> (m_data_reg.power_val == '0 && !m_data_reg.power_saturated), "zero depth with nonzero power")
    `PSP_ASSERT(a_zero_matches_w, aclk, aresetn, (m_valid_reg && m_data_reg.depth_zero) |-> (m_data_reg.proj_w == '0), "depth flag without zero w")
    `PSP_ASSERT(a_sat_at_limit, aclk, aresetn, (m_valid_reg && m_data_reg.power_saturated) |-> (m_data_reg.power_val == POWER_MAX || m_data_reg.power_val == POWER_MIN), "saturated power off limit")
    `PSP_ASSERT_NEVER(a_stall_source, aclk, aresetn, !s_ready && !(m_valid_reg && !m_ready), "input stalled without output backpressure")

endmodule

`default_nettype wire
